>>> rtl/core/sld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed settle detector package
// Shared types, codes and constants for the speed settle detector.
// ----------------------------------------------------------------------------
package sld_pkg;

	// Field widths
	localparam int RPM_W   = 10;
	localparam int SUM_W   = 11;
	localparam int THR_W   = 10;
	localparam int PROD_W  = 21;

	// Value limits and scale
	localparam logic [RPM_W-1:0] RPM_LIMIT    = RPM_W'(600);
	localparam logic [SUM_W-1:0] SUM_LIMIT    = SUM_W'(1200);
	localparam logic [PROD_W-1:0] SETTLE_SCALE = PROD_W'(1000);
	localparam logic [THR_W-1:0] THR_RESET    = THR_W'(918);

	// Command codes
	localparam logic [1:0] CMD_SAMPLE    = 2'd0;
	localparam logic [1:0] CMD_ENGAGE    = 2'd1;
	localparam logic [1:0] CMD_DISENGAGE = 2'd2;

	// Run modes
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_UP   = 2'd1,
		MODE_DOWN = 2'd2,
		MODE_AT   = 2'd3
	} mode_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVICT,
		ST_WRITE,
		ST_SCAN,
		ST_MUL,
		ST_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic rd_evict;
		logic write;
		logic scan;
		logic mul;
		logic finish;
	} sld_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic scan_done;
	} sld_stat_t;

	// Clamp a speed reading to the rpm limit
	function automatic logic [RPM_W-1:0] sat_rpm(input logic [RPM_W-1:0] v);
		return (v > RPM_LIMIT) ? RPM_LIMIT : v;
	endfunction

endpackage

>>> rtl/core/speed_settle_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed settle detector
// Sliding-window settle detection for a pair of motor speed readings.
// ----------------------------------------------------------------------------
// Each item takes a command and two speed readings and returns one result
// item with the run mode, the reached-speed event and the window min, max and
// fill state. The item steps through evict, write, window scan, multiply and
// finish; the scan walks every sample held after the push through the single
// read port of the sample ring, and no new item is taken until the result is
// registered. A finished result waits in the output register while the next
// item is taken in; a result still stalled when the next one finishes holds
// the block until it is taken.
module speed_settle_detector #(
	parameter int WINDOW_DEPTH = 50
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,     // ratio_threshold_permille
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,       // target_rpm, primary_rpm, secondary_rpm, zero pad
	input  logic [1:0]  s_tuser,       // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata        // mode, reached_speed, window_min, window_max,
	                                   // window_full, zero pad
);
	import sld_pkg::*;

	sld_cmd_t         cmd;
	sld_stat_t        stat;
	logic [1:0]       out_mode;
	logic             out_reached;
	logic [SUM_W-1:0] out_min, out_max;
	logic             out_full;

	sld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sld_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_cmd       (s_tuser),
		.in_target    (s_tdata[9:0]),
		.in_primary   (s_tdata[19:10]),
		.in_secondary (s_tdata[29:20]),
		.out_mode     (out_mode),
		.out_reached  (out_reached),
		.out_min      (out_min),
		.out_max      (out_max),
		.out_full     (out_full)
	);

	// Pack the result item
	assign m_tdata = {6'd0, out_full, out_max, out_min, out_reached, out_mode};

endmodule

>>> rtl/core/sld_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed settle detector controller
// Sequences one item through evict, write, window scan, multiply and result.
// ----------------------------------------------------------------------------
module sld_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  sld_pkg::sld_stat_t stat,
	output sld_pkg::sld_cmd_t  cmd
);
	import sld_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;

	// State register and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_EVICT;
				end
			end
			ST_EVICT: begin
				cmd.rd_evict = 1'b1;
				state_nxt    = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

>>> rtl/core/sld_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed settle detector datapath
// Sample ring memory, window min/max scan, ratio products and mode update.
// ----------------------------------------------------------------------------
module sld_datapath #(
	parameter int WINDOW_DEPTH = 50
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sld_pkg::sld_cmd_t         cmd,
	output sld_pkg::sld_stat_t        stat,
	input  logic                      cfg_we,
	input  logic [sld_pkg::THR_W-1:0] cfg_wdata,
	input  logic [1:0]                in_cmd,
	input  logic [sld_pkg::RPM_W-1:0] in_target,
	input  logic [sld_pkg::RPM_W-1:0] in_primary,
	input  logic [sld_pkg::RPM_W-1:0] in_secondary,
	output logic [1:0]                out_mode,
	output logic                      out_reached,
	output logic [sld_pkg::SUM_W-1:0] out_min,
	output logic [sld_pkg::SUM_W-1:0] out_max,
	output logic                      out_full
);
	import sld_pkg::*;

	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int ADR_W = CNT_W + 1;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);

	logic [SUM_W-1:0] mem [WINDOW_DEPTH];
	logic [SUM_W-1:0] rd_data_q;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_en;

	logic [THR_W-1:0] thr_q;
	mode_t            mode_q;
	logic [RPM_W-1:0] target_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] oldest_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] evicted_q;
	logic             evict_q;
	logic [IDX_W-1:0] scan_ptr_q;
	logic [CNT_W-1:0] scan_left_q;
	logic             rd_vld_s1;
	logic [SUM_W-1:0] lo_q, hi_q;
	logic [PROD_W-1:0] prod_lo_q, prod_hi_q;

	logic             full;
	logic [ADR_W-1:0] wr_sum;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] oldest_nxt;
	logic [CNT_W-1:0] count_nxt;
	logic [IDX_W-1:0] scan_ptr_inc;
	logic             ratio_ok, drop_ok, settle;
	logic [RPM_W-1:0] tgt_sat;

	assign full    = (count_q == DEPTH_CNT);
	assign tgt_sat = sat_rpm(in_target);

	// Slot for the new sample: oldest when full, else oldest plus count wrapped
	always_comb begin
		wr_sum = ADR_W'(oldest_q) + ADR_W'(count_q);
		if (full) begin
			wr_addr = oldest_q;
		end else if (wr_sum >= ADR_W'(WINDOW_DEPTH)) begin
			wr_addr = IDX_W'(wr_sum - ADR_W'(WINDOW_DEPTH));
		end else begin
			wr_addr = IDX_W'(wr_sum);
		end
		if (full) begin
			oldest_nxt = (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;
			count_nxt  = count_q;
		end else begin
			oldest_nxt = oldest_q;
			count_nxt  = count_q + 1'b1;
		end
	end

	// Read address: evicted slot, then the scan walk
	assign scan_ptr_inc = (scan_ptr_q == LAST_SLOT) ? '0 : scan_ptr_q + 1'b1;
	assign rd_en   = cmd.rd_evict || (cmd.scan && (scan_left_q != '0));
	assign rd_addr = cmd.rd_evict ? oldest_q : scan_ptr_q;

	// Sample memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[wr_addr] <= sum_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Settle test on the finished window
	assign ratio_ok = (prod_lo_q > prod_hi_q) && (lo_q < hi_q);
	assign drop_ok  = evict_q && (evicted_q > sum_q);
	assign settle   = ((mode_q == MODE_UP) || (mode_q == MODE_DOWN)) && full &&
			(ratio_ok || drop_ok);

	// Control state: threshold, mode, target, ring pointers, scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			mode_q      <= MODE_IDLE;
			target_q    <= '0;
			count_q     <= '0;
			oldest_q    <= '0;
			scan_left_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			rd_vld_s1 <= cmd.scan && (scan_left_q != '0);
			// Apply the command of the new item
			if (cmd.load) begin
				case (in_cmd)
					CMD_ENGAGE: begin
						if (target_q > tgt_sat) begin
							mode_q <= MODE_DOWN;
						end else if (target_q < tgt_sat) begin
							mode_q <= MODE_UP;
						end
						target_q <= tgt_sat;
						count_q  <= '0;
						oldest_q <= '0;
					end
					CMD_DISENGAGE: begin
						mode_q   <= MODE_IDLE;
						target_q <= '0;
						count_q  <= '0;
						oldest_q <= '0;
					end
					default: begin
					end
				endcase
			end
			// Push the sample and start the walk at the oldest entry
			if (cmd.write) begin
				count_q     <= count_nxt;
				oldest_q    <= oldest_nxt;
				scan_left_q <= count_nxt;
			end else if (cmd.scan && (scan_left_q != '0)) begin
				scan_left_q <= scan_left_q - 1'b1;
			end
			if (cmd.finish && settle) begin
				mode_q <= MODE_AT;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_q <= SUM_W'(sat_rpm(in_primary)) + SUM_W'(sat_rpm(in_secondary));
		end
		if (cmd.write) begin
			evicted_q  <= rd_data_q;
			evict_q    <= full;
			scan_ptr_q <= oldest_nxt;
			lo_q       <= SUM_LIMIT;
			hi_q       <= '0;
		end else if (cmd.scan && (scan_left_q != '0)) begin
			scan_ptr_q <= scan_ptr_inc;
		end
		// Fold each returned entry into min and max
		if (rd_vld_s1) begin
			if (rd_data_q < lo_q) begin
				lo_q <= rd_data_q;
			end
			if (rd_data_q > hi_q) begin
				hi_q <= rd_data_q;
			end
		end
		if (cmd.mul) begin
			prod_lo_q <= PROD_W'(lo_q) * SETTLE_SCALE;
			prod_hi_q <= PROD_W'(thr_q) * PROD_W'(hi_q);
		end
		// Hold the result for the output side
		if (cmd.finish) begin
			out_mode    <= settle ? MODE_AT : mode_q;
			out_reached <= settle && (mode_q == MODE_UP);
			out_min     <= lo_q;
			out_max     <= hi_q;
			out_full    <= full;
		end
	end

	assign stat.scan_done = (scan_left_q == '0) && !rd_vld_s1;

endmodule

>>> rtl/core/sld_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed settle detector checker
// Port-level checks on the result stream and the input handshake.
// ----------------------------------------------------------------------------
module sld_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);
	import sld_pkg::*;

	// A reached-speed event only comes with the at-speed mode
	a_reached_at: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> (m_tdata[1:0] == MODE_AT))
		else $error("reached_speed without at-speed mode");

	// The window always holds a sample, so min never exceeds max
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[13:3] <= m_tdata[24:14]))
		else $error("window_min above window_max");

	// Window max stays within the sum limit
	a_max_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[24:14] <= SUM_LIMIT))
		else $error("window_max out of range");

	// One item at a time: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on consecutive cycles");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind speed_settle_detector sld_checker u_sld_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
